>>> sv/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Phase and status codes plus fixed field widths shared by the receiver files.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// Fixed widths of the item fields.
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 16;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 6;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_STATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd2;

	// Receiver phases.
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ADDR,
		PH_LEN,
		PH_DATA,
		PH_CHK,
		PH_END,
		PH_EMIT
	} phase_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_PAYLOAD       = 3'd0,
		ST_ADDR_MISMATCH = 3'd1,
		ST_CHK_OK        = 3'd2,
		ST_CHK_BAD       = 3'd3,
		ST_BAD_END       = 3'd4,
		ST_EMPTY         = 3'd5,
		ST_TOO_LONG      = 3'd6
	} status_t;

endpackage

>>> sv/fpr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered and holds
// its value in cycles without a read enable.
// ----------------------------------------------------------------------------
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// Framed packet receiver core
// Hunts for framed packets in a byte stream, checks address, length and
// checksum, buffers the payload and delivers it as a run on the end marker.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per
// item. The output channel (out_valid, out_ready and the result fields) gives
// status results and payload runs through a single output register.
// A byte is taken in every cycle in which the output register is empty or
// being emptied, so a frame streams in at one byte per cycle; a byte that
// causes a result shows it in the cycle after it is accepted.
// On an accepted end marker of a frame with a nonempty payload the block stops
// taking bytes and reads the payload buffer, one entry a cycle while the
// receiver takes every result, through its registered RAM read port; a stall
// of the receiver holds the reads.
// While out_valid is high and out_ready is low the result holds and no byte is taken.
// The configuration port (cfg_we, cfg_index, cfg_data) writes a register at once;
// the user must use it only while the block is idle; the block does not check.
// Reset returns the block to hunting, empties the output register and loads
// the register defaults; the payload buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpr_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fpr_pkg::BYTE_W-1:0]         rx_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fpr_pkg::STATUS_W-1:0]       status,
	output logic [fpr_pkg::BYTE_W-1:0]         payload_byte,
	output logic [fpr_pkg::INDEX_W-1:0]        byte_index,
	output logic                               checksum_good,
	output logic                               last
);

	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	// Configuration registers.
	logic [fpr_pkg::ADDR_W-1:0] station_q;
	logic [fpr_pkg::BYTE_W-1:0] start_q;
	logic [fpr_pkg::BYTE_W-1:0] end_q;

	// Frame state.
	fpr_pkg::phase_t            phase_q, phase_d;
	logic [fpr_pkg::BYTE_W-1:0] addr_low_q, addr_low_d;
	logic                       high_next_q, high_next_d;
	logic [CNT_W-1:0]           length_q, length_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [fpr_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic                       matched_q, matched_d;

	// Run readout state.
	logic [CNT_W-1:0] issue_idx_q, issue_idx_d;
	logic             pending_q;
	logic [AW-1:0]    idx_s1;

	// Output register.
	logic                         out_valid_q;
	fpr_pkg::status_t             status_q;
	logic [fpr_pkg::BYTE_W-1:0]   byte_q;
	logic [fpr_pkg::INDEX_W-1:0]  index_q;
	logic                         good_q;
	logic                         last_q;

	// Result to load and RAM control.
	logic                         res_load;
	fpr_pkg::status_t             res_status;
	logic [fpr_pkg::BYTE_W-1:0]   res_byte;
	logic [fpr_pkg::INDEX_W-1:0]  res_index;
	logic                         res_good;
	logic                         res_last;
	logic                         ram_we;
	logic                         ram_re;
	logic [fpr_pkg::BYTE_W-1:0]   ram_rdata;

	logic                       load_ok;
	logic                       acc;
	logic [fpr_pkg::BYTE_W-1:0] sum_add;
	logic [CNT_W-1:0]           count_inc;
	logic [CNT_W-1:0]           idx_inc;

	// Handshake: bytes are refused while a run is read out or a result waits.
	assign load_ok   = !out_valid_q || out_ready;
	assign in_ready  = (phase_q != fpr_pkg::PH_EMIT) && load_ok;
	assign acc       = in_valid && in_ready;
	assign sum_add   = sum_q + rx_byte;
	assign count_inc = count_q + CNT_W'(1);
	assign idx_inc   = CNT_W'(idx_s1) + CNT_W'(1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
			start_q   <= 8'd2;
			end_q     <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpr_pkg::CFG_STATION: station_q <= cfg_data;
				fpr_pkg::CFG_START:   start_q   <= cfg_data[fpr_pkg::BYTE_W-1:0];
				fpr_pkg::CFG_END:     end_q     <= cfg_data[fpr_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Outputs of the phase machine: result to load, buffer writes and reads.
	always_comb begin
		res_load   = 1'b0;
		res_status = fpr_pkg::ST_PAYLOAD;
		res_byte   = '0;
		res_index  = '0;
		res_good   = 1'b0;
		res_last   = 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		unique case (phase_q)
			fpr_pkg::PH_HUNT: ;
			fpr_pkg::PH_ADDR: begin
				if (acc && high_next_q && ({rx_byte, addr_low_q} != station_q)) begin
					res_load   = 1'b1;
					res_status = fpr_pkg::ST_ADDR_MISMATCH;
				end
			end
			fpr_pkg::PH_LEN: begin
				if (acc && (rx_byte > fpr_pkg::BYTE_W'(MAX_PAYLOAD))) begin
					res_load   = 1'b1;
					res_status = fpr_pkg::ST_TOO_LONG;
				end
			end
			fpr_pkg::PH_DATA: begin
				ram_we = acc;
			end
			fpr_pkg::PH_CHK: begin
				if (acc) begin
					res_load   = 1'b1;
					res_good   = (rx_byte == sum_q);
					res_status = res_good ? fpr_pkg::ST_CHK_OK : fpr_pkg::ST_CHK_BAD;
				end
			end
			fpr_pkg::PH_END: begin
				if (acc) begin
					if (rx_byte != end_q) begin
						res_load   = 1'b1;
						res_status = fpr_pkg::ST_BAD_END;
					end else if (length_q == '0) begin
						res_load   = 1'b1;
						res_status = fpr_pkg::ST_EMPTY;
						res_good   = matched_q;
					end
				end
			end
			fpr_pkg::PH_EMIT: begin
				// A read is issued when no read data waits or the waiting data moves to the output register.
				ram_re     = (!pending_q || load_ok) && (issue_idx_q < length_q);
				res_load   = pending_q && load_ok;
				res_status = fpr_pkg::ST_PAYLOAD;
				res_byte   = ram_rdata;
				res_index  = fpr_pkg::INDEX_W'(idx_s1);
				res_good   = matched_q;
				res_last   = (idx_inc == length_q);
			end
			default: ;
		endcase
	end

	// Next phase and frame state.
	always_comb begin
		phase_d     = phase_q;
		addr_low_d  = addr_low_q;
		high_next_d = high_next_q;
		length_d    = length_q;
		count_d     = count_q;
		sum_d       = sum_q;
		matched_d   = matched_q;
		issue_idx_d = issue_idx_q;
		unique case (phase_q)
			fpr_pkg::PH_HUNT: begin
				if (acc && (rx_byte == start_q)) begin
					addr_low_d  = '0;
					high_next_d = 1'b0;
					length_d    = '0;
					count_d     = '0;
					sum_d       = '0;
					matched_d   = 1'b0;
					phase_d     = fpr_pkg::PH_ADDR;
				end
			end
			fpr_pkg::PH_ADDR: begin
				if (acc) begin
					sum_d = sum_add;
					if (!high_next_q) begin
						addr_low_d  = rx_byte;
						high_next_d = 1'b1;
					end else begin
						high_next_d = 1'b0;
						phase_d = ({rx_byte, addr_low_q} == station_q) ?
							fpr_pkg::PH_LEN : fpr_pkg::PH_HUNT;
					end
				end
			end
			fpr_pkg::PH_LEN: begin
				if (acc) begin
					sum_d = sum_add;
					if (rx_byte > fpr_pkg::BYTE_W'(MAX_PAYLOAD)) begin
						phase_d = fpr_pkg::PH_HUNT;
					end else begin
						length_d = CNT_W'(rx_byte);
						count_d  = '0;
						phase_d  = (rx_byte == '0) ? fpr_pkg::PH_CHK : fpr_pkg::PH_DATA;
					end
				end
			end
			fpr_pkg::PH_DATA: begin
				if (acc) begin
					sum_d   = sum_add;
					count_d = count_inc;
					if (count_inc >= length_q) begin
						phase_d = fpr_pkg::PH_CHK;
					end
				end
			end
			fpr_pkg::PH_CHK: begin
				if (acc) begin
					matched_d = (rx_byte == sum_q);
					phase_d   = fpr_pkg::PH_END;
				end
			end
			fpr_pkg::PH_END: begin
				if (acc) begin
					issue_idx_d = '0;
					if ((rx_byte == end_q) && (length_q != '0)) begin
						phase_d = fpr_pkg::PH_EMIT;
					end else begin
						phase_d = fpr_pkg::PH_HUNT;
					end
				end
			end
			fpr_pkg::PH_EMIT: begin
				if (ram_re) begin
					issue_idx_d = issue_idx_q + CNT_W'(1);
				end
				// The run ends when every entry is read and the last one is moved to the output register.
				if ((issue_idx_q == length_q) && (!pending_q || load_ok)) begin
					phase_d = fpr_pkg::PH_HUNT;
				end
			end
			default: phase_d = fpr_pkg::PH_HUNT;
		endcase
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fpr_pkg::PH_HUNT;
			addr_low_q  <= '0;
			high_next_q <= 1'b0;
			length_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			matched_q   <= 1'b0;
			issue_idx_q <= '0;
		end else begin
			phase_q     <= phase_d;
			addr_low_q  <= addr_low_d;
			high_next_q <= high_next_d;
			length_q    <= length_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			matched_q   <= matched_d;
			issue_idx_q <= issue_idx_d;
		end
	end

	// Read tracking: pending marks RAM read data not yet moved to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (ram_re) begin
			pending_q <= 1'b1;
		end else if (res_load && (phase_q == fpr_pkg::PH_EMIT)) begin
			pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= issue_idx_q[AW-1:0];
		end
	end

	// Payload buffer.
	fpr_ram #(
		.WIDTH (fpr_pkg::BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (issue_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			byte_q   <= res_byte;
			index_q  <= res_index;
			good_q   <= res_good;
			last_q   <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign payload_byte  = byte_q;
	assign byte_index    = index_q;
	assign checksum_good = good_q;
	assign last          = last_q;

endmodule

>>> sv/fpr_checker.sv
// ----------------------------------------------------------------------------
// Framed packet receiver checker
// Port-level assertions on the receiver core, attached by a bind statement.
// ----------------------------------------------------------------------------
module fpr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fpr_pkg::STATUS_W-1:0]  status,
	input logic [fpr_pkg::BYTE_W-1:0]    payload_byte,
	input logic [fpr_pkg::INDEX_W-1:0]   byte_index,
	input logic                          checksum_good,
	input logic                          last
);

	// A stalled result holds its status, byte, index and last fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(payload_byte) && $stable(byte_index) && $stable(last))
		else $error("stalled result changed");

	// No byte is taken while a result waits for the receiver.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte taken while result stalled");

	// Every status result stands alone with zero payload fields.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != fpr_pkg::ST_PAYLOAD) |->
		last && (payload_byte == '0) && (byte_index == '0))
		else $error("status result malformed");

	// Address, length and end-marker errors carry no checksum outcome.
	a_error_not_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == fpr_pkg::ST_ADDR_MISMATCH) ||
		(status == fpr_pkg::ST_BAD_END) || (status == fpr_pkg::ST_TOO_LONG)) |->
		!checksum_good)
		else $error("error result flagged good");

endmodule

bind framed_packet_receiver_core fpr_checker u_fpr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.payload_byte  (payload_byte),
	.byte_index    (byte_index),
	.checksum_good (checksum_good),
	.last          (last)
);
